/* rtl/core/bmi_pkg.sv */
package bmi_pkg;

    // Width of the register index carried on the configuration channel.
    localparam int CFG_INDEX_BITS = 8;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // take one operand word from the input transfer
        logic start;   // operand complete: initialize the loop registers
        logic step;    // run one iteration of the binary Euclidean loop
        logic finish;  // reduce the cofactor and fill the output buffer
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_word;  // the next operand word completes the operand
        logic v_zero;     // right-hand value has reached zero
        logic m_even;     // configured modulus is even (no inverse exists)
        logic out_busy;   // output buffer still holds words to deliver
    } dp_status_t;

endpackage

/* rtl/core/bmi_in_if.sv */
interface bmi_in_if #(
    parameter int WORD_BITS = 64
);
    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] operand_word;

    modport source (output valid, output operand_word, input ready);
    modport sink (input valid, input operand_word, output ready);
endinterface

/* rtl/core/bmi_out_if.sv */
interface bmi_out_if #(
    parameter int WORD_BITS = 64
);
    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] result_word;
    logic                 no_inverse;
    logic                 result_last;

    modport source (output valid, output result_word, output no_inverse,
                    output result_last, input ready);
    modport sink (input valid, input result_word, input no_inverse,
                  input result_last, output ready);
endinterface

/* rtl/core/bmi_cfg_if.sv */
interface bmi_cfg_if
    import bmi_pkg::*;
#(
    parameter int WORD_BITS = 64
);
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [WORD_BITS-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/core/binary_modular_inverse_256_top.sv */
// Modular inverse unit: computes a^-1 mod m with the binary extended Euclidean
// method. The odd modulus m is written as NWORDS words of WORD_BITS bits
// (registers 0 to NWORDS-1, least significant first); the user must write it
// only while the unit is idle, which the unit does not enforce. It resets to
// zero. The operand a arrives as NWORDS input transfers, least significant
// word first, and each complete operand yields NWORDS result transfers, least
// significant first, with result_last on the final word. When gcd(a, m) is
// above one, when a is zero and m is above one, or when m is even, every
// result word is zero and no_inverse is set. Per operand the unit takes the
// input words, runs the loop iterations of its single shift/subtract unit (at
// most about 4*OPERAND_BITS, typically about 2*OPERAND_BITS), notes that the
// loop has ended, does the final reduction and sends the output words. Words
// of the next operand, all but its last, are taken while the current one is
// still being processed; the result buffer drains during the next inversion.
module binary_modular_inverse_256_top
    import bmi_pkg::*;
#(
    parameter int OPERAND_BITS = 256,
    parameter int WORD_BITS    = 64
)(
    input  logic      clk,
    input  logic      rst_n,
    bmi_cfg_if.sink   cfg,
    bmi_in_if.sink    operand,
    bmi_out_if.source result
);

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       in_ready;

    // Configuration writes are always taken.
    assign cfg.ready     = 1'b1;
    assign operand.ready = in_ready;

    // Sequencer for loading, the loop and the final reduction.
    bmi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (operand.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Operand store, loop registers, modulus and output buffer.
    bmi_datapath #(
        .OPERAND_BITS (OPERAND_BITS),
        .WORD_BITS    (WORD_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .operand_word (operand.operand_word),
        .cfg_write    (cfg.valid),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .result_ready (result.ready),
        .result_valid (result.valid),
        .result_word  (result.result_word),
        .no_inverse   (result.no_inverse),
        .result_last  (result.result_last)
    );

endmodule

/* rtl/core/bmi_ctrl.sv */
module bmi_ctrl
    import bmi_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINAL
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Words before the last one are always taken; the last one only when the
    // loop registers are free.
    assign in_ready = !status.last_word || (state_reg == ST_IDLE);

    // Commands to the datapath.
    always_comb
    begin
        cmd.load   = in_valid && in_ready;
        cmd.start  = in_valid && in_ready && status.last_word;
        cmd.step   = (state_reg == ST_RUN) && !status.v_zero && !status.m_even;
        cmd.finish = (state_reg == ST_FINAL) && !status.out_busy;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (status.v_zero || status.m_even)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                if (!status.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/core/bmi_datapath.sv */
module bmi_datapath
    import bmi_pkg::*;
#(
    parameter int OPERAND_BITS = 256,
    parameter int WORD_BITS    = 64
)(
    input  logic                      clk,
    input  logic                      rst_n,
    input  dp_cmd_t                   cmd,
    output dp_status_t                status,
    input  logic [WORD_BITS-1:0]      operand_word,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [WORD_BITS-1:0]      cfg_data,
    input  logic                      result_ready,
    output logic                      result_valid,
    output logic [WORD_BITS-1:0]      result_word,
    output logic                      no_inverse,
    output logic                      result_last
);

    localparam int NWORDS   = (OPERAND_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int N        = NWORDS * WORD_BITS;
    localparam int CNT_BITS = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int OUT_BITS = $clog2(NWORDS + 1);

    // Control and configuration state.
    logic [N-1:0]        mod_reg, mod_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [OUT_BITS-1:0] out_left_reg, out_left_next;

    // Payload state.
    logic [N-1:0] op_reg, op_next;
    logic [N-1:0] hm_reg, hm_next;
    logic [N-1:0] u_reg, u_next;
    logic [N-1:0] v_reg, v_next;
    logic [N-1:0] r_reg, r_next;
    logic [N-1:0] s_reg, s_next;
    logic [N-1:0] res_reg, res_next;
    logic         flag_reg, flag_next;

    // Datapath signals.
    logic [N-1:0] word_ext;
    logic [N-1:0] operand_full;
    logic         last_word;
    logic [N-1:0] hv_in;
    logic [N-1:0] hv_out;
    logic [N:0]   uv_diff;
    logic [N-1:0] vu_diff;
    logic         u_gt;
    logic [N:0]   rs_diff;
    logic [N-1:0] rs_wrap;
    logic [N-1:0] rs_out;
    logic [N:0]   sr_diff;
    logic [N-1:0] sr_wrap;
    logic [N-1:0] sr_out;
    logic [N-1:0] ms_out;
    logic [N:0]   fin_diff;
    logic [N-1:0] fin_val;
    logic         fin_flag;
    logic         out_fire;

    // Incoming word lands in the top word; earlier words move down one place.
    assign word_ext     = N'(operand_word);
    assign operand_full = (word_ext << (N - WORD_BITS)) | (op_reg >> WORD_BITS);
    assign last_word    = (cnt_reg == CNT_BITS'(NWORDS - 1));

    // Modular halving of the cofactor that belongs to the even value.
    assign hv_in  = u_reg[0] ? s_reg : r_reg;
    assign hv_out = (hv_in >> 1) + (hv_in[0] ? hm_reg : '0);

    // Compare and subtract of the two odd values.
    assign uv_diff = {1'b0, u_reg} - {1'b0, v_reg};
    assign vu_diff = v_reg - u_reg;
    assign u_gt    = !uv_diff[N] && (uv_diff[N-1:0] != '0);

    // Modular subtraction of the cofactors in both directions, formed in
    // parallel with the compare; the compare only picks the outcome.
    assign rs_diff = {1'b0, r_reg} - {1'b0, s_reg};
    assign rs_wrap = r_reg - s_reg + mod_reg;
    assign rs_out  = rs_diff[N] ? rs_wrap : rs_diff[N-1:0];
    assign sr_diff = {1'b0, s_reg} - {1'b0, r_reg};
    assign sr_wrap = s_reg - r_reg + mod_reg;
    assign sr_out  = sr_diff[N] ? sr_wrap : sr_diff[N-1:0];
    assign ms_out  = u_gt ? rs_out : sr_out;

    // Final reduction of the cofactor and the no-inverse decision.
    assign fin_diff = {1'b0, r_reg} - {1'b0, mod_reg};
    assign fin_val  = fin_diff[N] ? r_reg : fin_diff[N-1:0];
    assign fin_flag = !mod_reg[0] || (u_reg[N-1:1] != '0);

    assign out_fire = result_valid && result_ready;

    // Status to the controller.
    always_comb
    begin
        status.last_word = last_word;
        status.v_zero    = (v_reg == '0);
        status.m_even    = !mod_reg[0];
        status.out_busy  = (out_left_reg != '0);
    end

    // Result channel.
    assign result_valid = (out_left_reg != '0);
    assign result_word  = res_reg[WORD_BITS-1:0];
    assign result_last  = (out_left_reg == OUT_BITS'(1));
    assign no_inverse   = flag_reg;

    // Modulus register writes.
    always_comb
    begin
        mod_next = mod_reg;
        for (int i = 0; i < NWORDS; i++)
        begin
            if (cfg_write && (cfg_index == CFG_INDEX_BITS'(i)))
            begin
                mod_next[i*WORD_BITS +: WORD_BITS] = cfg_data;
            end
        end
    end

    // Operand word count.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.load)
        begin
            cnt_next = last_word ? '0 : cnt_reg + CNT_BITS'(1);
        end
    end

    // Operand store.
    assign op_next = cmd.load ? operand_full : op_reg;

    // Loop registers: initialization and one loop iteration.
    always_comb
    begin
        hm_next = hm_reg;
        u_next  = u_reg;
        v_next  = v_reg;
        r_next  = r_reg;
        s_next  = s_reg;
        priority if (cmd.start)
        begin
            hm_next = (mod_reg >> 1) + N'(1);
            u_next  = mod_reg;
            v_next  = operand_full;
            r_next  = '0;
            s_next  = N'(1);
        end
        else if (cmd.step)
        begin
            priority if (!u_reg[0])
            begin
                u_next = u_reg >> 1;
                r_next = hv_out;
            end
            else if (!v_reg[0])
            begin
                v_next = v_reg >> 1;
                s_next = hv_out;
            end
            else if (u_gt)
            begin
                u_next = uv_diff[N-1:0];
                r_next = ms_out;
            end
            else
            begin
                v_next = vu_diff;
                s_next = ms_out;
            end
        end
    end

    // Output buffer: filled at finish, drained one word per transfer.
    always_comb
    begin
        res_next      = res_reg;
        flag_next     = flag_reg;
        out_left_next = out_left_reg;
        priority if (cmd.finish)
        begin
            res_next      = fin_flag ? '0 : fin_val;
            flag_next     = fin_flag;
            out_left_next = OUT_BITS'(NWORDS);
        end
        else if (out_fire)
        begin
            res_next      = res_reg >> WORD_BITS;
            out_left_next = out_left_reg - OUT_BITS'(1);
        end
    end

    // Control and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg      <= '0;
            cnt_reg      <= '0;
            out_left_reg <= '0;
        end
        else
        begin
            mod_reg      <= mod_next;
            cnt_reg      <= cnt_next;
            out_left_reg <= out_left_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        hm_reg   <= hm_next;
        u_reg    <= u_next;
        v_reg    <= v_next;
        r_reg    <= r_next;
        s_reg    <= s_next;
        res_reg  <= res_next;
        flag_reg <= flag_next;
    end

endmodule

/* rtl/core/bmi_checker.sv */
module bmi_checker #(
    parameter int WORD_BITS = 64
)(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 res_valid,
    input logic                 res_ready,
    input logic [WORD_BITS-1:0] res_word,
    input logic                 res_no_inverse,
    input logic                 res_last
);

    // A word flagged as having no inverse carries zero.
    a_no_inverse_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_no_inverse) |-> (res_word == '0))
        else $error("result word nonzero while no_inverse is set");

    // Within one result the next word follows and keeps the same flag.
    a_burst_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready && !res_last)
            |=> (res_valid && (res_no_inverse == $past(res_no_inverse))))
        else $error("result burst broken or no_inverse changed within it");

    // A result word offered and not taken stays offered.
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> res_valid)
        else $error("result valid dropped before transfer");

    // A stalled result word does not change.
    a_word_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> ($stable(res_word) && $stable(res_last)))
        else $error("stalled result word changed");

endmodule

bind binary_modular_inverse_256_top bmi_checker #(
    .WORD_BITS (WORD_BITS)
) u_bmi_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (result.valid),
    .res_ready      (result.ready),
    .res_word       (result.result_word),
    .res_no_inverse (result.no_inverse),
    .res_last       (result.result_last)
);

/* sim/testbench.sv */
module testbench
    import bmi_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int OPERAND_W = 256;
    localparam int WORD_W = 64;
    localparam int NUM_WORDS = OPERAND_W / WORD_W;
    localparam int SETTLE_CYCLES = 16;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int MAX_REPORTS = 10;

    // Register map of the configuration channel: the modulus words in order.
    localparam logic [CFG_INDEX_BITS-1:0] REG_MODULUS_WORD0 = 0;

    // Moduli used by the directed and random phases.
    localparam logic [OPERAND_W-1:0] FIELD_PRIME =
        256'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFE_FFFFFC2F;
    localparam logic [OPERAND_W-1:0] ALL_ONES = {OPERAND_W{1'b1}};

    typedef struct {
        logic [WORD_W-1:0] word;
        bit                drain_first;
    } operand_xfer_t;

    typedef struct {
        logic [WORD_W-1:0] word;
        logic              no_inv;
        logic              last;
    } inverse_word_t;

    logic clk = 1'b0;
    logic rst_n;

    bmi_cfg_if #(.WORD_BITS(WORD_W)) cfg_bus();
    bmi_in_if  #(.WORD_BITS(WORD_W)) in_bus();
    bmi_out_if #(.WORD_BITS(WORD_W)) out_bus();

    binary_modular_inverse_256_top #(
        .OPERAND_BITS(OPERAND_W),
        .WORD_BITS(WORD_W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg_bus),
        .operand(in_bus),
        .result(out_bus)
    );

    operand_xfer_t operand_queue[$];
    inverse_word_t expected_inverse_words[$];

    // Predictor state: modulus as written, and the operand being assembled.
    logic [OPERAND_W-1:0] modulus_model = '0;
    logic [OPERAND_W-1:0] operand_words = '0;
    int                   word_slot = 0;

    logic [OPERAND_W-1:0] target_modulus = '0;
    bit                   in_taken = 1'b0;
    int                   src_gap = 0;
    int                   src_calm = 0;
    int                   sink_stall = 0;
    int                   sink_calm = 0;
    int                   idle_cycles = 0;
    int                   failures = 0;
    int                   results_checked = 0;
    int                   no_inverse_seen = 0;
    int                   operands_sent = 0;
    int                   settings_count = 1;

    always #1 clk = ~clk;

    // Halve x modulo m, where half is (m + 1) / 2.
    function automatic logic [OPERAND_W-1:0] halve_mod(input logic [OPERAND_W-1:0] x,
                                                       input logic [OPERAND_W-1:0] half);
        if (x[0])
            return (x >> 1) + half;
        return x >> 1;
    endfunction

    // Subtract modulo m, adding m back when the difference borrows.
    function automatic logic [OPERAND_W-1:0] sub_mod(input logic [OPERAND_W-1:0] x,
                                                     input logic [OPERAND_W-1:0] y,
                                                     input logic [OPERAND_W-1:0] m);
        if (x < y)
            return x - y + m;
        return x - y;
    endfunction

    // Binary extended Euclid; returns 1 when no inverse exists (inv is then zero).
    function automatic bit find_inverse(input logic [OPERAND_W-1:0] m,
                                        input logic [OPERAND_W-1:0] a,
                                        output logic [OPERAND_W-1:0] inv);
        logic [OPERAND_W-1:0] u;
        logic [OPERAND_W-1:0] v;
        logic [OPERAND_W-1:0] r;
        logic [OPERAND_W-1:0] s;
        logic [OPERAND_W-1:0] half;
        inv = '0;
        if (!m[0])
            return 1'b1;
        half = (m >> 1) + 1;
        u = m;
        v = a;
        r = '0;
        s = 1;
        while (v != 0)
        begin
            if (!u[0])
            begin
                u = u >> 1;
                r = halve_mod(r, half);
            end
            else if (!v[0])
            begin
                v = v >> 1;
                s = halve_mod(s, half);
            end
            else if (u > v)
            begin
                u = u - v;
                r = sub_mod(r, s, m);
            end
            else
            begin
                v = v - u;
                s = sub_mod(s, r, m);
            end
        end
        if (u > 1)
            return 1'b1;
        inv = (r >= m) ? r - m : r;
        return 1'b0;
    endfunction

    function automatic logic [OPERAND_W-1:0] random_wide();
        logic [OPERAND_W-1:0] v;
        v = '0;
        for (int i = 0; i < OPERAND_W / 32; i++)
            v = {v[OPERAND_W-33:0], 32'($urandom())};
        return v;
    endfunction

    // Operand mix: mostly full-width values, plus small ones, multiples of m,
    // neighbors of m, short values and values with many low zero bits.
    function automatic logic [OPERAND_W-1:0] random_operand(input logic [OPERAND_W-1:0] m);
        logic [OPERAND_W-1:0] a;
        int mode;
        mode = $urandom_range(0, 9);
        case (mode)
            0, 1, 2, 3, 4: a = random_wide();
            5: a = $urandom_range(0, 40);
            6: a = m * $urandom_range(0, 3);
            7: a = $urandom_range(0, 1) ? m - 1 : m + 1;
            8: a = random_wide() >> (WORD_W * $urandom_range(1, NUM_WORDS - 1));
            default: a = random_wide() << $urandom_range(1, 200);
        endcase
        return a;
    endfunction

    // Idle lengths: mostly short, a few long, with occasional calm stretches.
    function automatic int pick_gap(inout int calm);
        int roll;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0)
        begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic note_failure(input string msg);
        failures++;
        if (failures <= MAX_REPORTS)
            $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    task automatic queue_operand(input logic [OPERAND_W-1:0] a, input bit drain);
        operand_xfer_t item;
        for (int i = 0; i < NUM_WORDS; i++)
        begin
            item.word = a[i*WORD_W +: WORD_W];
            item.drain_first = drain && (i == 0);
            operand_queue.push_back(item);
        end
        operands_sent++;
    endtask

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++)
            queue_operand(random_operand(target_modulus), $urandom_range(0, 7) == 0);
    endtask

    // Wait until all operands are sent and all inverse words have come back.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (operand_queue.size() != 0 || in_bus.valid || expected_inverse_words.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Load a new modulus once the block has gone idle.
    task automatic change_modulus(input logic [OPERAND_W-1:0] m);
        wait_drained();
        for (int i = 0; i < NUM_WORDS; i++)
        begin
            @(negedge clk);
            cfg_bus.valid <= 1'b1;
            cfg_bus.index <= REG_MODULUS_WORD0 + CFG_INDEX_BITS'(i);
            cfg_bus.data <= m[i*WORD_W +: WORD_W];
            do
                @(posedge clk);
            while (!cfg_bus.ready);
        end
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
        target_modulus = m;
        settings_count++;
    endtask

    // Operand driver: presents queued words, with random gaps between transfers.
    always @(negedge clk)
    begin : feed_operands
        if (!rst_n)
        begin
            in_bus.valid <= 1'b0;
        end
        else if (!in_bus.valid || in_taken)
        begin
            in_taken = 1'b0;
            if (src_gap > 0)
            begin
                src_gap--;
                in_bus.valid <= 1'b0;
            end
            else if (operand_queue.size() != 0 &&
                     !(operand_queue[0].drain_first && expected_inverse_words.size() != 0))
            begin
                in_bus.valid <= 1'b1;
                in_bus.operand_word <= operand_queue[0].word;
                void'(operand_queue.pop_front());
                src_gap = pick_gap(src_calm);
            end
            else
            begin
                in_bus.valid <= 1'b0;
            end
        end
    end

    // Result sink: random stalls on ready, independent of valid.
    always @(negedge clk)
    begin : pace_results
        if (!rst_n)
        begin
            out_bus.ready <= 1'b0;
        end
        else if (sink_stall > 0)
        begin
            sink_stall--;
            out_bus.ready <= 1'b0;
        end
        else
        begin
            out_bus.ready <= 1'b1;
            sink_stall = pick_gap(sink_calm);
        end
    end

    // Monitor: tracks every transfer, predicts inverses and checks results.
    always @(posedge clk)
    begin : watch_transfers
        inverse_word_t exp_w;
        logic [OPERAND_W-1:0] inv;
        bit flag;
        bit moved;
        if (rst_n)
        begin
            moved = 1'b0;

            // Modulus register writes.
            if (cfg_bus.valid && cfg_bus.ready)
            begin
                moved = 1'b1;
                if (cfg_bus.index < NUM_WORDS)
                    modulus_model[cfg_bus.index*WORD_W +: WORD_W] = cfg_bus.data;
            end

            // Operand words; a full operand yields four expected words.
            if (in_bus.valid && in_bus.ready)
            begin
                moved = 1'b1;
                in_taken = 1'b1;
                operand_words[word_slot*WORD_W +: WORD_W] = in_bus.operand_word;
                if (word_slot == NUM_WORDS - 1)
                begin
                    word_slot = 0;
                    flag = find_inverse(modulus_model, operand_words, inv);
                    for (int k = 0; k < NUM_WORDS; k++)
                    begin
                        exp_w.word = inv[k*WORD_W +: WORD_W];
                        exp_w.no_inv = flag;
                        exp_w.last = (k == NUM_WORDS - 1);
                        expected_inverse_words.push_back(exp_w);
                    end
                end
                else
                begin
                    word_slot++;
                end
            end

            // Result words against the oldest expectation.
            if (out_bus.valid && out_bus.ready)
            begin
                moved = 1'b1;
                if (expected_inverse_words.size() == 0)
                begin
                    note_failure($sformatf("unexpected result transfer: word=%h no_inverse=%b last=%b",
                                           out_bus.result_word, out_bus.no_inverse,
                                           out_bus.result_last));
                end
                else
                begin
                    exp_w = expected_inverse_words.pop_front();
                    if (exp_w.word !== out_bus.result_word ||
                        exp_w.no_inv !== out_bus.no_inverse ||
                        exp_w.last !== out_bus.result_last)
                        note_failure($sformatf({"result %0d: expected word=%h no_inverse=%b ",
                                                "last=%b, got word=%h no_inverse=%b last=%b"},
                                               results_checked, exp_w.word, exp_w.no_inv,
                                               exp_w.last, out_bus.result_word,
                                               out_bus.no_inverse, out_bus.result_last));
                    if (exp_w.no_inv)
                        no_inverse_seen++;
                end
                results_checked++;
            end

            // Watchdog on cycles without any transfer.
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("binary_modular_inverse_256_top test failed");
                $finish;
            end
        end
    end

    // Stimulus sequence.
    initial
    begin : stimulus
        logic [OPERAND_W-1:0] m;
        rst_n = 1'b0;
        in_bus.valid = 1'b0;
        in_bus.operand_word = '0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = '0;
        cfg_bus.data = '0;
        out_bus.ready = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // The modulus resets to zero, which is even: no inverse at all.
        queue_operand(ALL_ONES, 1'b0);

        // Modulus one: the result is zero without the no-inverse flag.
        change_modulus(256'd1);
        queue_operand(256'd5, 1'b0);

        // Prime modulus: zero, one, an operand above m, and m itself.
        change_modulus(FIELD_PRIME);
        queue_operand('0, 1'b0);
        queue_operand(256'd1, 1'b0);
        queue_operand(ALL_ONES, 1'b0);
        queue_operand(FIELD_PRIME, 1'b1);
        queue_random(12);

        // Full-width modulus with many small factors.
        change_modulus(ALL_ONES);
        queue_random(8);

        // Small modulus, so common factors show up often.
        change_modulus(256'd15);
        queue_random(8);

        // Even nonzero modulus.
        m = random_wide();
        m[0] = 1'b0;
        m[OPERAND_W-1] = 1'b1;
        change_modulus(m);
        queue_random(4);

        // Random odd full-width modulus.
        m = random_wide();
        m[0] = 1'b1;
        change_modulus(m);
        queue_random(12);

        // Random odd modulus that fits in one word.
        m = random_wide();
        m[OPERAND_W-1:WORD_W] = '0;
        m[0] = 1'b1;
        change_modulus(m);
        queue_random(8);

        wait_drained();

        $display("Summary: %0d operands over %0d modulus settings (zero, one, even, prime,",
                 operands_sent, settings_count);
        $display("Summary: full width and small moduli); %0d result words, %0d without inverse.",
                 results_checked, no_inverse_seen);
        if (failures == 0)
            $display("binary_modular_inverse_256_top test passed");
        else
            $display("binary_modular_inverse_256_top test failed");
        $finish;
    end

endmodule
